/* rtl/core/hu2ps2_pkg.sv */
`default_nettype none
package hu2ps2_pkg;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] BreakBit = 8'h80;
  localparam logic [15:0] UsagePrtsc = 16'h0046;
  localparam logic [15:0] UsagePause = 16'h0048;
  localparam logic [15:0] PrefixMask = 16'hFF00;
  localparam logic [15:0] CodePrtscExtra = 16'hE02A;
  localparam logic [15:0] CodePauseExtra = 16'hE11D;

  typedef enum logic [0:0] {
    KindKeyboard = 1'b0,
    KindConsumer = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] usage;
    logic        key_break;
  } event_t;

  typedef struct packed {
    logic [7:0] scan_byte;
    logic       status;
    logic       last;
  } result_t;

  // Classified event handed from front to back: up to four bytes, already final.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     err;
  } job_t;

  function automatic logic [15:0] kbd_code(input logic [7:0] u);
    logic [15:0] c;
    c = 16'h0000;
    case (u)
      8'h04: c = 16'h001e; 8'h05: c = 16'h0030; 8'h06: c = 16'h002e; 8'h07: c = 16'h0020;
      8'h08: c = 16'h0012; 8'h09: c = 16'h0021; 8'h0A: c = 16'h0022; 8'h0B: c = 16'h0023;
      8'h0C: c = 16'h0017; 8'h0D: c = 16'h0024; 8'h0E: c = 16'h0025; 8'h0F: c = 16'h0026;
      8'h10: c = 16'h0032; 8'h11: c = 16'h0031; 8'h12: c = 16'h0018; 8'h13: c = 16'h0019;
      8'h14: c = 16'h0010; 8'h15: c = 16'h0013; 8'h16: c = 16'h001f; 8'h17: c = 16'h0014;
      8'h18: c = 16'h0016; 8'h19: c = 16'h002f; 8'h1A: c = 16'h0011; 8'h1B: c = 16'h002d;
      8'h1C: c = 16'h0015; 8'h1D: c = 16'h002c; 8'h1E: c = 16'h0002; 8'h1F: c = 16'h0003;
      8'h20: c = 16'h0004; 8'h21: c = 16'h0005; 8'h22: c = 16'h0006; 8'h23: c = 16'h0007;
      8'h24: c = 16'h0008; 8'h25: c = 16'h0009; 8'h26: c = 16'h000a; 8'h27: c = 16'h000b;
      8'h28: c = 16'h001c; 8'h29: c = 16'h0001; 8'h2A: c = 16'h000e; 8'h2B: c = 16'h000f;
      8'h2C: c = 16'h0039; 8'h2D: c = 16'h000c; 8'h2E: c = 16'h000d; 8'h2F: c = 16'h001a;
      8'h30: c = 16'h001b; 8'h31: c = 16'h002b; 8'h32: c = 16'h002b; 8'h33: c = 16'h0027;
      8'h34: c = 16'h0028; 8'h35: c = 16'h0029; 8'h36: c = 16'h0033; 8'h37: c = 16'h0034;
      8'h38: c = 16'h0035; 8'h39: c = 16'h003a; 8'h3A: c = 16'h003b; 8'h3B: c = 16'h003c;
      8'h3C: c = 16'h003d; 8'h3D: c = 16'h003e; 8'h3E: c = 16'h003f; 8'h3F: c = 16'h0040;
      8'h40: c = 16'h0041; 8'h41: c = 16'h0042; 8'h42: c = 16'h0043; 8'h43: c = 16'h0044;
      8'h44: c = 16'h0057; 8'h45: c = 16'h0058; 8'h46: c = 16'hE037; 8'h47: c = 16'h0046;
      8'h48: c = 16'h0045; 8'h49: c = 16'hE052; 8'h4A: c = 16'hE047; 8'h4B: c = 16'hE049;
      8'h4C: c = 16'hE053; 8'h4D: c = 16'hE04F; 8'h4E: c = 16'hE051; 8'h4F: c = 16'hE04D;
      8'h50: c = 16'hE04B; 8'h51: c = 16'hE050; 8'h52: c = 16'hE048; 8'h53: c = 16'h0045;
      8'h54: c = 16'hE035; 8'h55: c = 16'h0037; 8'h56: c = 16'h004a; 8'h57: c = 16'h004e;
      8'h58: c = 16'hE01C; 8'h59: c = 16'h004f; 8'h5A: c = 16'h0050; 8'h5B: c = 16'h0051;
      8'h5C: c = 16'h004b; 8'h5D: c = 16'h004c; 8'h5E: c = 16'h004d; 8'h5F: c = 16'h0047;
      8'h60: c = 16'h0048; 8'h61: c = 16'h0049; 8'h62: c = 16'h0052; 8'h63: c = 16'h0053;
      8'h64: c = 16'h0056; 8'h65: c = 16'hE05D; 8'h66: c = 16'hE05E; 8'h67: c = 16'h0075;
      8'h68: c = 16'h00b7; 8'h69: c = 16'h00b8; 8'h6A: c = 16'h00b9; 8'h6B: c = 16'h00ba;
      8'h6C: c = 16'h00bb; 8'h6D: c = 16'h00bc; 8'h6E: c = 16'h00bd; 8'h6F: c = 16'h00be;
      8'h70: c = 16'h00bf; 8'h71: c = 16'h00c0; 8'h72: c = 16'h00c1; 8'h73: c = 16'h00c2;
      8'h74: c = 16'h0086; 8'h75: c = 16'h008a; 8'h76: c = 16'h0082; 8'h77: c = 16'h0084;
      8'h78: c = 16'h0080; 8'h79: c = 16'h0081; 8'h7A: c = 16'h0083; 8'h7B: c = 16'h0089;
      8'h7C: c = 16'h0085; 8'h7D: c = 16'h0087; 8'h7E: c = 16'h0088; 8'h7F: c = 16'h0071;
      8'h80: c = 16'h0073; 8'h81: c = 16'h0072; 8'h85: c = 16'h0079; 8'h87: c = 16'h0059;
      8'h88: c = 16'h005d; 8'h89: c = 16'h007c; 8'h8A: c = 16'h005c; 8'h8B: c = 16'h005e;
      8'h8C: c = 16'h005f; 8'h90: c = 16'h007a; 8'h91: c = 16'h007b; 8'h92: c = 16'h005a;
      8'h93: c = 16'h005b; 8'h94: c = 16'h0055;
      8'hE0: c = 16'h001D; 8'hE1: c = 16'h002A; 8'hE2: c = 16'h0038; 8'hE3: c = 16'hE05B;
      8'hE4: c = 16'hE01D; 8'hE5: c = 16'h0036; 8'hE6: c = 16'hE038; 8'hE7: c = 16'hE05C;
      8'hE8: c = 16'h00a4; 8'hE9: c = 16'h00a6; 8'hEA: c = 16'h00a5; 8'hEB: c = 16'h00a3;
      8'hEC: c = 16'h00a1; 8'hED: c = 16'h0073; 8'hEE: c = 16'h0072; 8'hEF: c = 16'h0071;
      8'hF0: c = 16'h0096; 8'hF1: c = 16'h009e; 8'hF2: c = 16'h009f; 8'hF3: c = 16'h0080;
      8'hF4: c = 16'h0088; 8'hF5: c = 16'h00b1; 8'hF6: c = 16'h00b2; 8'hF7: c = 16'h00b0;
      8'hF8: c = 16'h008e; 8'hF9: c = 16'h0098; 8'hFA: c = 16'h00ad; 8'hFB: c = 16'h008c;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] cons_code(input logic [15:0] u);
    logic [15:0] c;
    c = 16'h0000;
    case (u)
      16'h00B5: c = 16'hE019; 16'h00B6: c = 16'hE010; 16'h00B7: c = 16'hE024;
      16'h00CD: c = 16'hE022; 16'h00E2: c = 16'hE020; 16'h00E9: c = 16'hE030;
      16'h00EA: c = 16'hE02E; 16'h0183: c = 16'hE06D; 16'h018A: c = 16'hE06C;
      16'h0192: c = 16'hE021; 16'h0194: c = 16'hE06B; 16'h0221: c = 16'hE065;
      16'h0223: c = 16'hE032; 16'h0224: c = 16'hE06A; 16'h0225: c = 16'hE069;
      16'h0226: c = 16'hE068; 16'h0227: c = 16'hE067; 16'h022A: c = 16'hE066;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/hu2ps2_front.sv */
`default_nettype none
module hu2ps2_front import hu2ps2_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire event_t in_event,
  output logic        out_valid,
  output job_t        out_job
);

  logic        is_kbd;
  logic [15:0] code;
  job_t        job_next;

  // Append one code's bytes, prefix first, stopping at a zero byte.
  function automatic job_t put_code(input job_t j, input logic [15:0] c, input logic brk);
    job_t r;
    logic [7:0] b0;
    logic [7:0] b1;
    r = j;
    if ((c & PrefixMask) != 16'h0000) begin
      b0 = c[15:8];
      b1 = c[7:0];
    end else begin
      b0 = c[7:0];
      b1 = 8'h00;
    end
    if (b0 != 8'h00 && r.count < 3'(MaxBytes)) begin
      r.bytes[r.count[1:0]] = brk ? (b0 | BreakBit) : b0;
      r.count = r.count + 3'd1;
      if (b1 != 8'h00 && r.count < 3'(MaxBytes)) begin
        r.bytes[r.count[1:0]] = brk ? (b1 | BreakBit) : b1;
        r.count = r.count + 3'd1;
      end
    end
    return r;
  endfunction

  // Table lookup and byte sequence assembly
  always_comb begin
    is_kbd = (in_event.kind == KindKeyboard);
    if (is_kbd) begin
      code = (in_event.usage[15:8] == 8'h00) ? kbd_code(in_event.usage[7:0]) : 16'h0000;
    end else begin
      code = cons_code(in_event.usage);
    end
    job_next = '0;
    if (code == 16'h0000) begin
      job_next.err = 1'b1;
      job_next.count = 3'd1;
    end else begin
      if (is_kbd && in_event.usage == UsagePrtsc && !in_event.key_break) begin
        job_next = put_code(job_next, CodePrtscExtra, 1'b0);
      end
      if (is_kbd && in_event.usage == UsagePause) begin
        job_next = put_code(job_next, CodePauseExtra, in_event.key_break);
      end
      job_next = put_code(job_next, code, in_event.key_break);
      if (is_kbd && in_event.usage == UsagePrtsc && in_event.key_break) begin
        job_next = put_code(job_next, CodePrtscExtra, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_job <= job_next;
  end

endmodule
`default_nettype wire

/* rtl/core/hu2ps2_queue.sv */
`default_nettype none
module hu2ps2_queue import hu2ps2_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      empty,
  output logic      full,
  output job_t      head
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem [QueueDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [PtrW:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == (PtrW+1)'(QueueDepth));
  assign head  = mem[rptr];

  // Pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_job;
  end

endmodule
`default_nettype wire

/* rtl/core/hu2ps2_back.sv */
`default_nettype none
module hu2ps2_back import hu2ps2_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_done,
  output logic      strobe,
  output result_t   result
);

  logic [1:0] idx;
  logic       last_byte;

  assign last_byte = ({1'b0, idx} + 3'd1 == job.count);
  assign job_done  = job_valid && last_byte;

  // Byte sequencer: one byte per cycle from the queue head
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= job_valid;
      if (job_valid) idx <= last_byte ? 2'd0 : idx + 2'd1;
    end
    result.scan_byte <= job.bytes[idx];
    result.status    <= job.err;
    result.last      <= last_byte;
  end

endmodule
`default_nettype wire

/* rtl/core/hid_usage_to_ps2_scancode_unit.sv */
`default_nettype none
// An accepted start is registered in the front stage, queued, then sequenced into registered result bytes.
// Throughput: one result byte per cycle while the queue holds a job; an event's 1 to 4 bytes, by its byte count,
// leave one by one through the single-byte output sequencer.
// The receiver cannot stall; busy rises when the event queue is full or about to fill.
// Synchronous reset empties the queue and clears the sequencer; no tables need clearing.
module hid_usage_to_ps2_scancode_unit import hu2ps2_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire event_t in_data,
  output logic        busy,
  output logic        strobe,
  output result_t     out_data
);

  logic f_valid;
  job_t f_job;
  logic q_empty;
  logic q_full;
  job_t q_head;
  logic q_pop;
  logic accept;
  logic fill_one;

  // Busy one slot early so a job still in the front register always finds room.
  assign busy   = q_full || (f_valid && fill_one);
  assign accept = start && !busy;

  assign fill_one = !q_empty && !q_full && !q_pop;

  hu2ps2_front u_front (
    .clk(clk), .rst(rst), .in_valid(accept), .in_event(in_data),
    .out_valid(f_valid), .out_job(f_job)
  );

  hu2ps2_queue u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .push_job(f_job), .pop(q_pop),
    .empty(q_empty), .full(q_full), .head(q_head)
  );

  hu2ps2_back u_back (
    .clk(clk), .rst(rst), .job_valid(!q_empty), .job(q_head),
    .job_done(q_pop), .strobe(strobe), .result(out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (!q_full || q_pop))
    else $error("event queue overflow");
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && out_data.status) |-> (out_data.last && out_data.scan_byte == 8'h00))
    else $error("error result malformed");
  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(!q_empty))
    else $error("strobe without queued job");
`endif

endmodule
`default_nettype wire

/* tb/hid_usage_to_ps2_scancode_unit_tb.sv */
`default_nettype none
module hid_usage_to_ps2_scancode_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hu2ps2_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomEvents = 480;

  logic    clk;
  logic    rst;
  logic    start;
  event_t  in_data;
  logic    busy;
  logic    strobe;
  result_t out_data;

  hid_usage_to_ps2_scancode_unit dut (
    .clk(clk), .rst(rst), .start(start), .in_data(in_data),
    .busy(busy), .strobe(strobe), .out_data(out_data)
  );

  event_t  pending_events[$];
  result_t expected_bytes[$];
  int      idle_pct;
  int      fail_count;
  int      quiet_cycles;
  bit      taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Scancode table for the keyboard page; zero means unmapped
  function automatic logic [15:0] keyboard_scancode(input logic [15:0] u);
    logic [15:0] tbl [0:255];
    int i;
    for (i = 0; i < 256; i++) tbl[i] = 16'h0000;
    // letters
    tbl[8'h04] = 16'h001e; tbl[8'h05] = 16'h0030; tbl[8'h06] = 16'h002e;
    tbl[8'h07] = 16'h0020; tbl[8'h08] = 16'h0012; tbl[8'h09] = 16'h0021;
    tbl[8'h0A] = 16'h0022; tbl[8'h0B] = 16'h0023; tbl[8'h0C] = 16'h0017;
    tbl[8'h0D] = 16'h0024; tbl[8'h0E] = 16'h0025; tbl[8'h0F] = 16'h0026;
    tbl[8'h10] = 16'h0032; tbl[8'h11] = 16'h0031; tbl[8'h12] = 16'h0018;
    tbl[8'h13] = 16'h0019; tbl[8'h14] = 16'h0010; tbl[8'h15] = 16'h0013;
    tbl[8'h16] = 16'h001f; tbl[8'h17] = 16'h0014; tbl[8'h18] = 16'h0016;
    tbl[8'h19] = 16'h002f; tbl[8'h1A] = 16'h0011; tbl[8'h1B] = 16'h002d;
    tbl[8'h1C] = 16'h0015; tbl[8'h1D] = 16'h002c;
    // digits, control keys, function keys
    for (i = 8'h1E; i <= 8'h26; i++) tbl[i] = 16'(i - 8'h1E + 2);
    tbl[8'h27] = 16'h000b; tbl[8'h28] = 16'h001c; tbl[8'h29] = 16'h0001;
    tbl[8'h2A] = 16'h000e; tbl[8'h2B] = 16'h000f; tbl[8'h2C] = 16'h0039;
    tbl[8'h2D] = 16'h000c; tbl[8'h2E] = 16'h000d; tbl[8'h2F] = 16'h001a;
    tbl[8'h30] = 16'h001b; tbl[8'h31] = 16'h002b; tbl[8'h32] = 16'h002b;
    tbl[8'h33] = 16'h0027; tbl[8'h34] = 16'h0028; tbl[8'h35] = 16'h0029;
    tbl[8'h36] = 16'h0033; tbl[8'h37] = 16'h0034; tbl[8'h38] = 16'h0035;
    for (i = 8'h39; i <= 8'h43; i++) tbl[i] = 16'(i - 8'h39 + 8'h3a);
    tbl[8'h44] = 16'h0057; tbl[8'h45] = 16'h0058; tbl[8'h46] = 16'hE037;
    tbl[8'h47] = 16'h0046; tbl[8'h48] = 16'h0045; tbl[8'h49] = 16'hE052;
    tbl[8'h4A] = 16'hE047; tbl[8'h4B] = 16'hE049; tbl[8'h4C] = 16'hE053;
    tbl[8'h4D] = 16'hE04F; tbl[8'h4E] = 16'hE051; tbl[8'h4F] = 16'hE04D;
    tbl[8'h50] = 16'hE04B; tbl[8'h51] = 16'hE050; tbl[8'h52] = 16'hE048;
    tbl[8'h53] = 16'h0045; tbl[8'h54] = 16'hE035; tbl[8'h55] = 16'h0037;
    tbl[8'h56] = 16'h004a; tbl[8'h57] = 16'h004e; tbl[8'h58] = 16'hE01C;
    tbl[8'h59] = 16'h004f; tbl[8'h5A] = 16'h0050; tbl[8'h5B] = 16'h0051;
    tbl[8'h5C] = 16'h004b; tbl[8'h5D] = 16'h004c; tbl[8'h5E] = 16'h004d;
    tbl[8'h5F] = 16'h0047; tbl[8'h60] = 16'h0048; tbl[8'h61] = 16'h0049;
    tbl[8'h62] = 16'h0052; tbl[8'h63] = 16'h0053; tbl[8'h64] = 16'h0056;
    tbl[8'h65] = 16'hE05D; tbl[8'h66] = 16'hE05E; tbl[8'h67] = 16'h0075;
    for (i = 8'h68; i <= 8'h73; i++) tbl[i] = 16'(i - 8'h68 + 8'hb7);
    tbl[8'h74] = 16'h0086; tbl[8'h75] = 16'h008a; tbl[8'h76] = 16'h0082;
    tbl[8'h77] = 16'h0084; tbl[8'h78] = 16'h0080; tbl[8'h79] = 16'h0081;
    tbl[8'h7A] = 16'h0083; tbl[8'h7B] = 16'h0089; tbl[8'h7C] = 16'h0085;
    tbl[8'h7D] = 16'h0087; tbl[8'h7E] = 16'h0088; tbl[8'h7F] = 16'h0071;
    tbl[8'h80] = 16'h0073; tbl[8'h81] = 16'h0072; tbl[8'h85] = 16'h0079;
    tbl[8'h87] = 16'h0059; tbl[8'h88] = 16'h005d; tbl[8'h89] = 16'h007c;
    tbl[8'h8A] = 16'h005c; tbl[8'h8B] = 16'h005e; tbl[8'h8C] = 16'h005f;
    tbl[8'h90] = 16'h007a; tbl[8'h91] = 16'h007b; tbl[8'h92] = 16'h005a;
    tbl[8'h93] = 16'h005b; tbl[8'h94] = 16'h0055;
    tbl[8'hE0] = 16'h001D; tbl[8'hE1] = 16'h002A; tbl[8'hE2] = 16'h0038;
    tbl[8'hE3] = 16'hE05B; tbl[8'hE4] = 16'hE01D; tbl[8'hE5] = 16'h0036;
    tbl[8'hE6] = 16'hE038; tbl[8'hE7] = 16'hE05C; tbl[8'hE8] = 16'h00a4;
    tbl[8'hE9] = 16'h00a6; tbl[8'hEA] = 16'h00a5; tbl[8'hEB] = 16'h00a3;
    tbl[8'hEC] = 16'h00a1; tbl[8'hED] = 16'h0073; tbl[8'hEE] = 16'h0072;
    tbl[8'hEF] = 16'h0071; tbl[8'hF0] = 16'h0096; tbl[8'hF1] = 16'h009e;
    tbl[8'hF2] = 16'h009f; tbl[8'hF3] = 16'h0080; tbl[8'hF4] = 16'h0088;
    tbl[8'hF5] = 16'h00b1; tbl[8'hF6] = 16'h00b2; tbl[8'hF7] = 16'h00b0;
    tbl[8'hF8] = 16'h008e; tbl[8'hF9] = 16'h0098; tbl[8'hFA] = 16'h00ad;
    tbl[8'hFB] = 16'h008c;
    if (u > 16'd255) return 16'h0000;
    return tbl[u[7:0]];
  endfunction

  localparam logic [15:0] ConsumerUsages [18] = '{16'h00B5, 16'h00B6, 16'h00B7,
    16'h00CD, 16'h00E2, 16'h00E9, 16'h00EA, 16'h0183, 16'h018A, 16'h0192, 16'h0194,
    16'h0221, 16'h0223, 16'h0224, 16'h0225, 16'h0226, 16'h0227, 16'h022A};
  localparam logic [7:0] ConsumerLow [18] = '{8'h19, 8'h10, 8'h24, 8'h22, 8'h20,
    8'h30, 8'h2E, 8'h6D, 8'h6C, 8'h21, 8'h6B, 8'h65, 8'h32, 8'h6A, 8'h69, 8'h68,
    8'h67, 8'h66};

  // Append one code's bytes, prefix first, halting at a zero byte
  function automatic void emit_code(input logic [15:0] code, input logic brk,
                                    inout logic [7:0] seq[$]);
    logic [7:0] b [2];
    int cnt;
    int i;
    if ((code & PrefixMask) != 0) begin
      b[0] = code[15:8]; b[1] = code[7:0]; cnt = 2;
    end else begin
      b[0] = code[7:0]; cnt = 1;
    end
    for (i = 0; i < cnt; i++) begin
      if (b[i] == 8'h00 || seq.size() >= MaxBytes) break;
      seq.push_back(brk ? (b[i] | BreakBit) : b[i]);
    end
  endfunction

  // Expected scancode bytes of one key event
  function automatic void predict_scancodes(input event_t ev);
    logic [15:0] code;
    logic [7:0] seq[$];
    logic kbd;
    result_t r;
    int k;
    kbd = (ev.kind == KindKeyboard);
    code = 16'h0000;
    if (kbd) code = keyboard_scancode(ev.usage);
    else
      for (k = 0; k < 18; k++)
        if (ConsumerUsages[k] == ev.usage) begin
          code = {8'hE0, ConsumerLow[k]};
          break;
        end
    if (code == 16'h0000) begin
      r.scan_byte = 8'h00; r.status = 1'b1; r.last = 1'b1;
      expected_bytes.push_back(r);
      return;
    end
    if (kbd && ev.usage == UsagePrtsc && !ev.key_break)
      emit_code(CodePrtscExtra, ev.key_break, seq);
    if (kbd && ev.usage == UsagePause) emit_code(CodePauseExtra, ev.key_break, seq);
    emit_code(code, ev.key_break, seq);
    if (kbd && ev.usage == UsagePrtsc && ev.key_break)
      emit_code(CodePrtscExtra, ev.key_break, seq);
    foreach (seq[i]) begin
      r.scan_byte = seq[i]; r.status = 1'b0; r.last = (i == seq.size() - 1);
      expected_bytes.push_back(r);
    end
  endfunction

  function automatic void add_event(input logic kind, input logic [15:0] usage,
                                    input logic brk);
    event_t ev;
    ev.kind = kind; ev.usage = usage; ev.key_break = brk;
    pending_events.push_back(ev);
  endfunction

  // Driver: present the next event at the falling edge, hold it until transfer
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // not yet taken; hold
    end else begin
      if (start) void'(pending_events.pop_front());
      if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_data <= pending_events[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on each transfer, check each strobed byte
  always @(posedge clk) begin
    if (!rst) begin
      taken <= start && !busy;
      if ((start && !busy) || strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        predict_scancodes(in_data);
      end
      if (strobe) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          if (out_data !== expected_bytes[0]) begin
            $display("%0t: mismatch, expected byte %h status %b last %b, actual %h %b %b",
                     $time, expected_bytes[0].scan_byte, expected_bytes[0].status,
                     expected_bytes[0].last, out_data.scan_byte, out_data.status,
                     out_data.last);
            fail_count++;
          end
          void'(expected_bytes.pop_front());
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    int phase;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    in_data = '0;
    idle_pct = 0;
    fail_count = 0;
    quiet_cycles = 0;
    taken = 1'b0;

    // Directed: extremes, Print Screen and Pause, consumer hits and misses
    add_event(KindKeyboard, 16'h0046, 1'b0);
    add_event(KindKeyboard, 16'h0046, 1'b1);
    add_event(KindKeyboard, 16'h0048, 1'b0);
    add_event(KindKeyboard, 16'h0048, 1'b1);
    add_event(KindKeyboard, 16'h0000, 1'b0);
    add_event(KindKeyboard, 16'h00FF, 1'b1);
    add_event(KindKeyboard, 16'h0100, 1'b0);
    add_event(KindKeyboard, 16'hFFFF, 1'b1);
    add_event(KindKeyboard, 16'h0004, 1'b0);
    add_event(KindKeyboard, 16'h0004, 1'b1);
    add_event(KindKeyboard, 16'h0058, 1'b0);
    add_event(KindKeyboard, 16'h0058, 1'b1);
    add_event(KindKeyboard, 16'h00E7, 1'b1);
    add_event(KindKeyboard, 16'h0082, 1'b0);
    add_event(KindConsumer, 16'h00B5, 1'b0);
    add_event(KindConsumer, 16'h022A, 1'b1);
    add_event(KindConsumer, 16'h0046, 1'b0);
    add_event(KindConsumer, 16'h0048, 1'b1);
    add_event(KindConsumer, 16'h0000, 1'b0);
    add_event(KindConsumer, 16'hFFFF, 1'b1);
    add_event(KindConsumer, 16'hC22A, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Random phases: mostly mapped keys, some any usage at all
    for (phase = 0; phase < 4; phase++) begin
      wait (pending_events.size() == 0);
      idle_pct = (phase == 1) ? 80 : (phase == 3) ? 11 : 0;
      for (i = 0; i < RandomEvents / 4; i++) begin
        pick = $urandom_range(9);
        if (pick < 5)
          add_event(KindKeyboard, 16'($urandom_range(255)), 1'($urandom));
        else if (pick < 7)
          add_event(KindConsumer, ConsumerUsages[$urandom_range(17)], 1'($urandom));
        else if (pick < 8)
          add_event(KindKeyboard, ($urandom_range(1) ? 16'h0046 : 16'h0048),
                    1'($urandom));
        else
          add_event(1'($urandom), 16'($urandom), 1'($urandom));
      end
    end
    wait (pending_events.size() == 0);
    wait (expected_bytes.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
